// File: sv/jmds_pkg.sv
// shared constants for the jet / missing-energy azimuth difference selector
// no dependencies
package jmds_pkg;

  // default parameter values
  localparam int unsigned MaxJetsDef       = 64;
  localparam int unsigned AngleFracBitsDef = 12;

  // fixed field widths
  localparam int unsigned AngleW  = 15;  // signed azimuth inputs
  localparam int unsigned IdxOutW = 6;   // index outputs
  localparam int unsigned NearW   = 16;  // nearest magnitude output
  localparam int unsigned FarW    = 14;  // farthest magnitude output
  localparam int unsigned MagW    = 15;  // any wrapped magnitude fits here

endpackage

// File: sv/jmds_dphi.sv
// wrapped azimuth difference magnitude, one jet per cycle, combinational
// depends on jmds_pkg
module jmds_dphi import jmds_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic [AngleW-1:0] jet_azimuth_i,
  input  logic [AngleW-1:0] met_azimuth_i,
  output logic [MagW-1:0]   dphi_o
);

  localparam longint AngOne    = longint'(1) << ANGLE_FRAC_BITS;
  localparam longint WrapLimit = (314 * AngOne) / 100;
  localparam longint WrapStep  = (628 * AngOne + 50) / 100;
  localparam int     StepBits  = $clog2(WrapStep + 1);
  localparam int     DW        = (StepBits + 2 > 17) ? StepBits + 2 : 17;

  localparam logic signed [DW-1:0] LimitPos = DW'(WrapLimit);
  localparam logic signed [DW-1:0] LimitNeg = DW'(-WrapLimit);
  localparam logic signed [DW-1:0] StepS    = DW'(WrapStep);

  logic signed [DW-1:0] jet_ext;
  logic signed [DW-1:0] met_ext;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] wrapped;
  logic signed [DW-1:0] abs_val;

  assign jet_ext = $signed({{(DW-AngleW){jet_azimuth_i[AngleW-1]}}, jet_azimuth_i});
  assign met_ext = $signed({{(DW-AngleW){met_azimuth_i[AngleW-1]}}, met_azimuth_i});
  assign diff    = jet_ext - met_ext;

  // single wrap in either direction
  always_comb begin
    priority if (diff > LimitPos) begin
      wrapped = diff - StepS;
    end else if (diff < LimitNeg) begin
      wrapped = diff + StepS;
    end else begin
      wrapped = diff;
    end
  end

  assign abs_val = wrapped[DW-1] ? -wrapped : wrapped;
  assign dphi_o  = abs_val[MagW-1:0];

endmodule

// File: sv/jet_met_dphi_min_max_select.sv
// top level: nearest / farthest jet selector by azimuth difference to missing energy
// depends on jmds_pkg and jmds_dphi
//
// One jet transaction is taken every clock cycle unless input stall is high. Each
// jet goes into an input register; while it is held there its wrapped azimuth
// difference to the missing energy is formed, its magnitude is compared against
// the running smallest and largest of the event, and the event state is updated
// as it moves on. On the jet marked last the result (both indices and magnitudes,
// this jet included) is loaded into the output register, and the event state
// returns to its start values for the next event. Jets that are not last produce
// no output transaction. Ties keep the earlier jet; the jet index saturates at
// MAX_JETS-1 and is reported in its low six bits. Input stall rises only while a
// last jet is held behind an unaccepted result.
module jet_met_dphi_min_max_select import jmds_pkg::*; #(
  parameter int unsigned MAX_JETS        = MaxJetsDef,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // jet stream
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [AngleW-1:0]  jet_azimuth_i,
  input  logic [AngleW-1:0]  met_azimuth_i,
  input  logic               last_jet_i,
  // event result
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IdxOutW-1:0] nearest_index_o,
  output logic [NearW-1:0]   nearest_dphi_o,
  output logic [IdxOutW-1:0] farthest_index_o,
  output logic [FarW-1:0]    farthest_dphi_o
);

  localparam int     IdxW     = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam longint MinStart = longint'(10) << ANGLE_FRAC_BITS;
  localparam int     MinBits  = $clog2(MinStart + 1);
  localparam int     MinW     = (MinBits > NearW) ? MinBits : NearW;

  localparam logic [IdxW-1:0] IdxLast     = IdxW'(MAX_JETS - 1);
  localparam logic [MinW-1:0] MinStartVal = MinW'(MinStart);

  // input register
  logic              in_valid_q;
  logic [AngleW-1:0] jet_q;
  logic [AngleW-1:0] met_q;
  logic              last_q;

  // event state
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [MinW-1:0]   min_val_q, min_val_d;
  logic [IdxW-1:0]   min_idx_q, min_idx_d;
  logic [MagW-1:0]   max_val_q, max_val_d;
  logic [IdxW-1:0]   max_idx_q, max_idx_d;

  // result register
  logic              out_valid_q;
  logic [IdxW-1:0]   res_min_idx_q;
  logic [MinW-1:0]   res_min_val_q;
  logic [IdxW-1:0]   res_max_idx_q;
  logic [MagW-1:0]   res_max_val_q;

  logic              fire;
  logic              in_take;
  logic [MagW-1:0]   mag;
  logic [MinW-1:0]   mag_ext;
  logic [MinW-1:0]   new_min_val;
  logic [IdxW-1:0]   new_min_idx;
  logic [MagW-1:0]   new_max_val;
  logic [IdxW-1:0]   new_max_idx;

  logic [IdxW+IdxOutW-1:0] near_idx_ext;
  logic [IdxW+IdxOutW-1:0] far_idx_ext;

  // the held jet moves on unless it is last and the result slot is busy
  assign fire       = in_valid_q & (~last_q | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~fire;
  assign in_take    = in_valid_i & ~in_stall_o;

  jmds_dphi #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dphi (
    .jet_azimuth_i(jet_q),
    .met_azimuth_i(met_q),
    .dphi_o       (mag)
  );

  assign mag_ext = {{(MinW-MagW){1'b0}}, mag};

  // strict compares keep the first jet on a tie
  always_comb begin
    new_max_val = max_val_q;
    new_max_idx = max_idx_q;
    new_min_val = min_val_q;
    new_min_idx = min_idx_q;
    if (mag > max_val_q) begin
      new_max_val = mag;
      new_max_idx = cnt_q;
    end
    if (mag_ext < min_val_q) begin
      new_min_val = mag_ext;
      new_min_idx = cnt_q;
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    min_val_d = min_val_q;
    min_idx_d = min_idx_q;
    max_val_d = max_val_q;
    max_idx_d = max_idx_q;
    if (fire) begin
      if (last_q) begin
        // event done, back to start values
        cnt_d     = '0;
        min_val_d = MinStartVal;
        min_idx_d = '0;
        max_val_d = '0;
        max_idx_d = '0;
      end else begin
        min_val_d = new_min_val;
        min_idx_d = new_min_idx;
        max_val_d = new_max_val;
        max_idx_d = new_max_idx;
        // saturate at the last index
        if (cnt_q != IdxLast) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  // control and event state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      min_val_q   <= MinStartVal;
      min_idx_q   <= '0;
      max_val_q   <= '0;
      max_idx_q   <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire && last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      cnt_q     <= cnt_d;
      min_val_q <= min_val_d;
      min_idx_q <= min_idx_d;
      max_val_q <= max_val_d;
      max_idx_q <= max_idx_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      jet_q  <= jet_azimuth_i;
      met_q  <= met_azimuth_i;
      last_q <= last_jet_i;
    end
    if (fire && last_q) begin
      res_min_idx_q <= new_min_idx;
      res_min_val_q <= new_min_val;
      res_max_idx_q <= new_max_idx;
      res_max_val_q <= new_max_val;
    end
  end

  // indices go out in their low six bits, zero padded if narrower
  assign near_idx_ext = {{IdxOutW{1'b0}}, res_min_idx_q};
  assign far_idx_ext  = {{IdxOutW{1'b0}}, res_max_idx_q};

  assign out_valid_o      = out_valid_q;
  assign nearest_index_o  = near_idx_ext[IdxOutW-1:0];
  assign nearest_dphi_o   = res_min_val_q[NearW-1:0];
  assign farthest_index_o = far_idx_ext[IdxOutW-1:0];
  assign farthest_dphi_o  = res_max_val_q[FarW-1:0];

endmodule

// File: sim/dphi_select_check.sv
// event result predictor and comparator for jet_met_dphi_min_max_select
// depends on jmds_pkg; watches both channels, reports mismatches and pending events
module dphi_select_check import jmds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [AngleW-1:0]  jet_azimuth_i,
  input  logic [AngleW-1:0]  met_azimuth_i,
  input  logic               last_jet_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [IdxOutW-1:0] nearest_index_i,
  input  logic [NearW-1:0]   nearest_dphi_i,
  input  logic [IdxOutW-1:0] farthest_index_i,
  input  logic [FarW-1:0]    farthest_dphi_i,
  output int                 error_count_o,
  output int                 pending_o
);

  // angle grid constants in 2^-F rad units
  localparam int AngOne    = 1 << AngleFracBitsDef;
  localparam int WrapLimit = (314 * AngOne) / 100;
  localparam int WrapStep  = (628 * AngOne + 50) / 100;
  localparam int NearStart = 10 * AngOne;
  localparam int TopIdx    = MaxJetsDef - 1;

  typedef struct {
    logic [IdxOutW-1:0] nearest_index;
    logic [NearW-1:0]   nearest_dphi;
    logic [IdxOutW-1:0] farthest_index;
    logic [FarW-1:0]    farthest_dphi;
  } event_result_t;

  event_result_t event_results_q[$];

  // running event state
  int unsigned      jet_index;
  logic [NearW-1:0] nearest_best;
  int unsigned      nearest_at;
  logic [NearW-1:0] farthest_best;
  int unsigned      farthest_at;
  int               mismatches;

  // wrapped azimuth difference magnitude, single wrap in either direction
  function automatic logic [NearW-1:0] folded_dphi(logic [AngleW-1:0] jet,
                                                   logic [AngleW-1:0] met);
    int d;
    d = int'($signed(jet)) - int'($signed(met));
    if (d > WrapLimit) begin
      d = d - WrapStep;
    end else if (d < -WrapLimit) begin
      d = d + WrapStep;
    end
    if (d < 0) begin
      d = -d;
    end
    return d[NearW-1:0];
  endfunction

  task automatic clear_event_state();
    jet_index     = 0;
    nearest_best  = NearW'(NearStart);
    nearest_at    = 0;
    farthest_best = '0;
    farthest_at   = 0;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    event_result_t    want;
    logic [NearW-1:0] mag;
    if (!rst_ni) begin
      clear_event_state();
      event_results_q.delete();
      mismatches = 0;
    end else begin
      // result side first: a jet taken at this edge cannot already have a result
      if (out_valid_i && !out_stall_i) begin
        if (event_results_q.size() == 0) begin
          $error("event result with no event pending: nearest %0d/%0d farthest %0d/%0d",
                 nearest_index_i, nearest_dphi_i, farthest_index_i, farthest_dphi_i);
          mismatches++;
        end else begin
          want = event_results_q.pop_front();
          check_field("nearest_index", want.nearest_index, nearest_index_i);
          check_field("nearest_dphi", want.nearest_dphi, nearest_dphi_i);
          check_field("farthest_index", want.farthest_index, farthest_index_i);
          check_field("farthest_dphi", want.farthest_dphi, farthest_dphi_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        mag = folded_dphi(jet_azimuth_i, met_azimuth_i);
        // strict compares, first jet wins a tie
        if (mag > farthest_best) begin
          farthest_best = mag;
          farthest_at   = jet_index;
        end
        if (mag < nearest_best) begin
          nearest_best = mag;
          nearest_at   = jet_index;
        end
        if (jet_index < TopIdx) begin
          jet_index++;
        end
        if (last_jet_i) begin
          want.nearest_index  = nearest_at[IdxOutW-1:0];
          want.nearest_dphi   = nearest_best;
          want.farthest_index = farthest_at[IdxOutW-1:0];
          want.farthest_dphi  = farthest_best[FarW-1:0];
          event_results_q = {event_results_q, want};
          clear_event_state();
        end
      end
    end
    error_count_o <= mismatches;
    pending_o     <= event_results_q.size();
  end

endmodule

// File: sim/jet_met_dphi_min_max_select_tb.sv
// testbench top for jet_met_dphi_min_max_select: jet stream stimulus and verdict
// depends on jmds_pkg, the block itself and dphi_select_check
module jet_met_dphi_min_max_select_tb;
  import jmds_pkg::*;

  localparam int ItemTarget  = 1200;    // jets in the random part
  localparam int QuietItems  = 300;     // jets sent with no idling on either side
  localparam int IdlePercent = 37;
  localparam int CycleLimit  = 200000;  // far above the slowest correct run
  localparam int AzRange     = 12868;   // nominal azimuth bound, 1/4096 rad
  localparam int WrapEdge    = 12861;   // wrap threshold on the default grid

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;

  // jet stream
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [AngleW-1:0]  jet_azimuth = '0;
  logic [AngleW-1:0]  met_azimuth = '0;
  logic               last_jet    = 1'b0;

  // event result
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [IdxOutW-1:0] nearest_index;
  logic [NearW-1:0]   nearest_dphi;
  logic [IdxOutW-1:0] farthest_index;
  logic [FarW-1:0]    farthest_dphi;

  // idling switches, both sides
  bit idle_en  = 1'b0;
  bit stall_en = 1'b0;

  int cycle_count = 0;
  int jets_sent   = 0;
  int error_count;
  int pending;

  jet_met_dphi_min_max_select u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .jet_azimuth_i    (jet_azimuth),
    .met_azimuth_i    (met_azimuth),
    .last_jet_i       (last_jet),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .nearest_index_o  (nearest_index),
    .nearest_dphi_o   (nearest_dphi),
    .farthest_index_o (farthest_index),
    .farthest_dphi_o  (farthest_dphi)
  );

  // predicts each event result and compares it with what the block delivers
  dphi_select_check u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .jet_azimuth_i    (jet_azimuth),
    .met_azimuth_i    (met_azimuth),
    .last_jet_i       (last_jet),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .nearest_index_i  (nearest_index),
    .nearest_dphi_i   (nearest_dphi),
    .farthest_index_i (farthest_index),
    .farthest_dphi_i  (farthest_dphi),
    .error_count_o    (error_count),
    .pending_o        (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure, random per cycle while enabled
  always @(posedge clk) begin
    out_stall <= stall_en && ($urandom_range(99) < IdlePercent);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // missing-energy azimuth: mostly in range, sometimes any 15-bit pattern
  function automatic int random_met();
    if ($urandom_range(99) < 80) begin
      return int'($urandom_range(2 * AzRange)) - AzRange;
    end
    return int'($urandom_range(32767));
  endfunction

  // jet azimuth, shaped around the wrap threshold and around ties
  function automatic int random_jet(int met);
    int kind;
    int off;
    kind = $urandom_range(99);
    if (kind < 55) begin
      return int'($urandom_range(2 * AzRange)) - AzRange;
    end
    if (kind < 72) begin
      // difference just below, at or just above the wrap threshold
      off = WrapEdge - 3 + int'($urandom_range(6));
      if ($urandom_range(1) == 1) begin
        off = -off;
      end
      return met + off;
    end
    if (kind < 85) begin
      // tiny differences, repeats give ties
      return met + int'($urandom_range(8)) - 4;
    end
    return int'($urandom_range(32767));
  endfunction

  // mostly short events, a few long enough to saturate the jet index
  function automatic int event_length();
    if ($urandom_range(99) < 6) begin
      return $urandom_range(80, 60);
    end
    return $urandom_range(12, 1);
  endfunction

  // one jet transaction; valid only drops when the sender takes a gap
  task automatic send_jet(input int jet, input int met, input bit last);
    if (idle_en && ($urandom_range(99) < IdlePercent)) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < IdlePercent);
    end
    in_valid    <= 1'b1;
    jet_azimuth <= jet[AngleW-1:0];
    met_azimuth <= met[AngleW-1:0];
    last_jet    <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic send_event(input int n_jets);
    int met;
    met = random_met();
    for (int i = 0; i < n_jets; i++) begin
      // now and then the missing-energy angle moves inside an event
      if ($urandom_range(19) == 0) begin
        met = random_met();
      end
      send_jet(random_jet(met), met, i == n_jets - 1);
      jets_sent++;
    end
  endtask

  // sender holds off until every expected event result is in
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n    <= 1'b1;
    idle_en  <= 1'b1;
    stall_en <= 1'b1;
    @(posedge clk);

    // single jet event with zero difference: both picks at index 0, value 0
    send_jet(0, 0, 1'b1);

    // wrap in both directions, threshold edges, raw out-of-range patterns, ties
    send_jet(AzRange, -AzRange, 1'b0);
    send_jet(-AzRange, AzRange, 1'b0);
    send_jet(WrapEdge, 0, 1'b0);
    send_jet(WrapEdge + 1, 0, 1'b0);
    send_jet(0, WrapEdge, 1'b0);
    send_jet(0, WrapEdge + 1, 1'b0);
    send_jet(16383, 16384, 1'b0);
    send_jet(16384, 16383, 1'b0);
    send_jet(0, 0, 1'b1);

    // all differences zero over several jets: farthest stays at index 0
    send_jet(5000, 5000, 1'b0);
    send_jet(-7000, -7000, 1'b0);
    send_jet(AzRange, AzRange, 1'b1);

    // all-ones and sign-bit-only patterns
    send_jet(32767, 0, 1'b0);
    send_jet(0, 32767, 1'b0);
    send_jet(16384, 16384, 1'b1);

    wait_for_results();

    // long stretch with no idling on either side, switched off at once
    idle_en  = 1'b0;
    stall_en = 1'b0;
    while (jets_sent < QuietItems) begin
      send_event(event_length());
    end

    // idling back on, after a full drain
    idle_en  <= 1'b1;
    stall_en <= 1'b1;
    wait_for_results();
    while (jets_sent < ItemTarget) begin
      send_event(event_length());
    end

    // drain, then a few cycles for anything stray from the two-stage pipe
    wait_for_results();
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
